FILE: hdl/mss_pkg.sv
package mss_pkg;

  localparam int MAX_ROWS_DEF = 256;
  localparam int MAX_COLS_DEF = 256;

  localparam int ELEM_W   = 16;
  localparam int CFG_W    = 9;
  localparam int SUM_W    = 32;
  localparam int CORNER_W = 9;

  localparam int SUM_MAX = 32'sh7fffffff;
  localparam int SUM_MIN = -32'sh7fffffff - 1;

  localparam logic [0:0] REG_ROW_COUNT = 1'b0;
  localparam logic [0:0] REG_COL_COUNT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic signed [ELEM_W-1:0] element;
    logic                     last_element;
  } request_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] best_sum;
    logic [CORNER_W-1:0]     top_row;
    logic [CORNER_W-1:0]     left_col;
    logic [CORNER_W-1:0]     bottom_row;
    logic [CORNER_W-1:0]     right_col;
  } result_t;

endpackage

FILE: hdl/max_sum_submatrix.sv
// Maximum-sum sub-rectangle search over a stored signed matrix.
// Configure row_count and col_count (register 0 and 1) while the block is idle.
// A count of zero is taken as one, and a count above the maximum as the maximum.
// Elements arrive in row-major order, one request per cycle, accepted when start
// is high and busy is low. Elements beyond rows*cols are dropped.
// The request flagged last_element starts the search and raises busy.
// For each top row, each bottom row is walked through the columns by one shared
// pipeline that reads the matrix and column-sum memories, updates the column sum
// and then adds it to the running sum and compares, one column per cycle with an
// idle gap after each row, and the pipeline drains when the search ends.
// The result is then shown for exactly one cycle with done high, and busy falls.
// The receiver cannot stall the result.
// Reset clears the configuration to one by one, the load position and the
// control state; the matrix memory holds whatever was last written.
module max_sum_submatrix #(
  parameter int MAX_ROWS = mss_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = mss_pkg::MAX_COLS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  mss_pkg::request_t          request,
  output logic                       done,
  output mss_pkg::result_t           result,
  input  logic                       cfg_we,
  input  logic [0:0]                 cfg_index,
  input  logic [mss_pkg::CFG_W-1:0]  cfg_data
);

  localparam int LR     = $clog2(MAX_ROWS);
  localparam int LC     = $clog2(MAX_COLS);
  localparam int ROW_IW = (LR > 0) ? LR : 1;
  localparam int COL_IW = (LC > 0) ? LC : 1;
  localparam int CNT_R  = $clog2(MAX_ROWS + 1);
  localparam int CNT_C  = $clog2(MAX_COLS + 1);
  localparam int DEPTH  = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LP_W   = $clog2(DEPTH + 1);
  localparam int CS_W   = mss_pkg::ELEM_W + LR;
  localparam int RUN_W  = (mss_pkg::ELEM_W + LR + LC > 33) ? mss_pkg::ELEM_W + LR + LC : 33;
  localparam int AREA_W = (LR + LC > 0) ? LR + LC : 1;

  localparam logic signed [RUN_W-1:0] SAT_HI = RUN_W'(mss_pkg::SUM_MAX);
  localparam logic signed [RUN_W-1:0] SAT_LO = RUN_W'(mss_pkg::SUM_MIN);

  mss_pkg::state_t state, state_next;

  logic [mss_pkg::CFG_W-1:0] row_count, col_count;
  logic [CNT_R-1:0] rows_eff, rows_q;
  logic [CNT_C-1:0] cols_eff, cols_q;
  logic [LP_W-1:0]  total, load_pos;

  logic signed [mss_pkg::ELEM_W-1:0] matrix [DEPTH];
  logic signed [CS_W-1:0]            colsum [MAX_COLS];

  logic accept, mat_we;

  logic [ROW_IW-1:0] top, bot;
  logic [COL_IW-1:0] col;
  logic [ADDR_W-1:0] top_base, bot_base, cols_ext;
  logic              gap;
  logic              issue, last_col, last_bot, last_top, last_issue;

  logic                              s1_valid, s1_first_row, s1_first_col;
  logic [COL_IW-1:0]                 s1_col;
  logic [ROW_IW-1:0]                 s1_top, s1_bot;
  logic signed [mss_pkg::ELEM_W-1:0] mat_rd;
  logic signed [CS_W-1:0]            cs_rd, cs_new;

  logic                   s2_valid, s2_first_col;
  logic [COL_IW-1:0]      s2_col;
  logic [ROW_IW-1:0]      s2_top, s2_bot;
  logic signed [CS_W-1:0] s2_cs;

  logic signed [RUN_W-1:0] run, run_cur, best;
  logic [COL_IW-1:0]       left, left_cur;
  logic [AREA_W-1:0]       area, area_cur, best_area;
  logic                    have, win;
  logic [ROW_IW-1:0]       best_top, best_bot;
  logic [COL_IW-1:0]       best_left, best_right;

  always_comb begin
    if (row_count == '0) begin
      rows_eff = CNT_R'(1);
    end else if (32'(row_count) > MAX_ROWS) begin
      rows_eff = CNT_R'(MAX_ROWS);
    end else begin
      rows_eff = CNT_R'(row_count);
    end
    if (col_count == '0) begin
      cols_eff = CNT_C'(1);
    end else if (32'(col_count) > MAX_COLS) begin
      cols_eff = CNT_C'(MAX_COLS);
    end else begin
      cols_eff = CNT_C'(col_count);
    end
  end

  assign total  = LP_W'(32'(rows_eff) * 32'(cols_eff));
  assign busy   = (state != mss_pkg::ST_IDLE);
  assign accept = start && !busy;
  assign mat_we = accept && (load_pos < total);

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= mss_pkg::CFG_W'(1);
      col_count <= mss_pkg::CFG_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        mss_pkg::REG_ROW_COUNT: row_count <= cfg_data;
        mss_pkg::REG_COL_COUNT: col_count <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      load_pos <= '0;
    end else if (accept) begin
      if (request.last_element) begin
        load_pos <= '0;
      end else if (mat_we) begin
        load_pos <= load_pos + LP_W'(1);
      end
    end
  end

  assign cols_ext = ADDR_W'(cols_q);
  assign last_col = (CNT_C'(col) + CNT_C'(1)) == cols_q;
  assign last_bot = (CNT_R'(bot) + CNT_R'(1)) == rows_q;
  assign last_top = (CNT_R'(top) + CNT_R'(1)) == rows_q;

  always_comb begin
    state_next = state;
    issue      = 1'b0;
    last_issue = 1'b0;
    done       = 1'b0;
    case (state)
      mss_pkg::ST_IDLE: begin
        if (accept && request.last_element) begin
          state_next = mss_pkg::ST_SCAN;
        end
      end
      mss_pkg::ST_SCAN: begin
        issue      = !gap;
        last_issue = !gap && last_col && last_bot && last_top;
        if (last_issue) begin
          state_next = mss_pkg::ST_DRAIN;
        end
      end
      mss_pkg::ST_DRAIN: begin
        if (!s1_valid && !s2_valid) begin
          state_next = mss_pkg::ST_DONE;
        end
      end
      mss_pkg::ST_DONE: begin
        done       = 1'b1;
        state_next = mss_pkg::ST_IDLE;
      end
      default: state_next = mss_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mss_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gap <= 1'b0;
    end else if (state == mss_pkg::ST_IDLE) begin
      gap <= 1'b0;
    end else begin
      gap <= issue && last_col;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && request.last_element) begin
      rows_q   <= rows_eff;
      cols_q   <= cols_eff;
      top      <= '0;
      bot      <= '0;
      col      <= '0;
      top_base <= '0;
      bot_base <= '0;
    end else if (issue) begin
      if (!last_col) begin
        col <= col + COL_IW'(1);
      end else begin
        col <= '0;
        if (!last_bot) begin
          bot      <= bot + ROW_IW'(1);
          bot_base <= bot_base + cols_ext;
        end else if (!last_top) begin
          top      <= top + ROW_IW'(1);
          bot      <= top + ROW_IW'(1);
          top_base <= top_base + cols_ext;
          bot_base <= top_base + cols_ext;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mat_we) begin
      matrix[load_pos[ADDR_W-1:0]] <= request.element;
    end
    mat_rd <= matrix[bot_base + ADDR_W'(col)];
  end

  assign cs_new = s1_first_row ? CS_W'(mat_rd) : cs_rd + CS_W'(mat_rd);

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      colsum[s1_col] <= cs_new;
    end
    cs_rd <= colsum[col];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= issue;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_col       <= col;
    s1_top       <= top;
    s1_bot       <= bot;
    s1_first_row <= (bot == top);
    s1_first_col <= (col == '0);
    s2_col       <= s1_col;
    s2_top       <= s1_top;
    s2_bot       <= s1_bot;
    s2_first_col <= s1_first_col;
    s2_cs        <= cs_new;
  end

  assign run_cur  = (s2_first_col ? '0 : run) + RUN_W'(s2_cs);
  assign area_cur = s2_first_col ? '0 : area;
  assign left_cur = s2_first_col ? '0 : left;
  assign win      = !have || (run_cur > best) || ((run_cur == best) && (area_cur < best_area));

  always_ff @(posedge clk) begin
    if (rst) begin
      have <= 1'b0;
    end else if (accept && request.last_element) begin
      have <= 1'b0;
    end else if (s2_valid) begin
      have <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_valid) begin
      if (win) begin
        best       <= run_cur;
        best_area  <= area_cur;
        best_top   <= s2_top;
        best_left  <= left_cur;
        best_bot   <= s2_bot;
        best_right <= s2_col;
      end
      if (run_cur <= 0) begin
        run  <= '0;
        left <= s2_col + COL_IW'(1);
        area <= '0;
      end else begin
        run  <= run_cur;
        left <= left_cur;
        area <= area_cur + AREA_W'(s2_bot - s2_top);
      end
    end
  end

  always_comb begin
    if (best > SAT_HI) begin
      result.best_sum = mss_pkg::SUM_W'(mss_pkg::SUM_MAX);
    end else if (best < SAT_LO) begin
      result.best_sum = mss_pkg::SUM_W'(mss_pkg::SUM_MIN);
    end else begin
      result.best_sum = best[mss_pkg::SUM_W-1:0];
    end
    result.top_row    = mss_pkg::CORNER_W'(32'(best_top) + 32'd1);
    result.left_col   = mss_pkg::CORNER_W'(32'(best_left) + 32'd1);
    result.bottom_row = mss_pkg::CORNER_W'(32'(best_bot) + 32'd1);
    result.right_col  = mss_pkg::CORNER_W'(32'(best_right) + 32'd1);
  end

endmodule

FILE: test/tb_max_sum_submatrix.sv
`timescale 1ns / 1ps

module tb_max_sum_submatrix;

  localparam int MAX_R = mss_pkg::MAX_ROWS_DEF;
  localparam int MAX_C = mss_pkg::MAX_COLS_DEF;
  localparam int SETTLE_CYCLES = 8;
  localparam int WATCHDOG_LIMIT = 300000;
  localparam int PHASE_ITEMS = 330;

  typedef enum {SHAPE_RANDOM, SHAPE_EARLY} shape_t;

  typedef struct {
    bit                  is_cfg;
    logic [8:0]          rows_val;
    logic [8:0]          cols_val;
    mss_pkg::request_t   req;
    bit                  typed;
    mss_pkg::result_t    want;
  } plan_step_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  mss_pkg::request_t request = '0;
  logic done;
  mss_pkg::result_t result;
  logic cfg_we = 1'b0;
  logic [0:0] cfg_index = mss_pkg::REG_ROW_COUNT;
  logic [mss_pkg::CFG_W-1:0] cfg_data = '0;

  logic signed [mss_pkg::ELEM_W-1:0] matrix_copy [MAX_R*MAX_C];
  logic [mss_pkg::CFG_W-1:0] rows_reg = 9'd1;
  logic [mss_pkg::CFG_W-1:0] cols_reg = 9'd1;
  int unsigned load_pos = 0;
  int unsigned written_extent = 0;
  int unsigned items_applied = 0;

  mss_pkg::result_t awaited_rectangles[$];
  mss_pkg::result_t oldest;
  plan_step_t plan[$];
  int errors = 0;
  int quiet_cycles = 0;

  max_sum_submatrix dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .request(request),
    .done(done),
    .result(result),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  function automatic int unsigned clamp_count(int unsigned v, int unsigned maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function automatic mss_pkg::result_t search_best_rectangle(int unsigned rows,
                                                             int unsigned cols);
    longint col_sum [MAX_C];
    longint run;
    longint best;
    int unsigned left;
    int unsigned area;
    int unsigned best_area;
    int unsigned corner [4];
    bit found;
    mss_pkg::result_t res;
    found = 1'b0;
    best = 0;
    best_area = 0;
    corner = '{default: 0};
    for (int unsigned top = 0; top < rows; top++) begin
      for (int unsigned c = 0; c < cols; c++) col_sum[c] = 0;
      for (int unsigned bottom = top; bottom < rows; bottom++) begin
        left = 0;
        run = 0;
        for (int unsigned c = 0; c < cols; c++) begin
          col_sum[c] += matrix_copy[bottom*cols + c];
          area = (c - left) * (bottom - top);
          run += col_sum[c];
          if (!found || run > best || (run == best && area < best_area)) begin
            found = 1'b1;
            best = run;
            best_area = area;
            corner = '{top, left, bottom, c};
          end
          if (run <= 0) begin
            run = 0;
            left = c + 1;
          end
        end
      end
    end
    if (best > 64'(mss_pkg::SUM_MAX)) best = 64'(mss_pkg::SUM_MAX);
    if (best < 64'(mss_pkg::SUM_MIN)) best = 64'(mss_pkg::SUM_MIN);
    res.best_sum = best[31:0];
    res.top_row = mss_pkg::CORNER_W'(corner[0] + 1);
    res.left_col = mss_pkg::CORNER_W'(corner[1] + 1);
    res.bottom_row = mss_pkg::CORNER_W'(corner[2] + 1);
    res.right_col = mss_pkg::CORNER_W'(corner[3] + 1);
    return res;
  endfunction

  function automatic bit predict_request(input mss_pkg::request_t req,
                                         output mss_pkg::result_t res);
    int unsigned rows;
    int unsigned cols;
    bit stored;
    rows = clamp_count(32'(rows_reg), MAX_R);
    cols = clamp_count(32'(cols_reg), MAX_C);
    res = '0;
    stored = load_pos < rows * cols;
    if (stored) begin
      matrix_copy[load_pos] = req.element;
      load_pos++;
      if (load_pos > written_extent) written_extent = load_pos;
    end
    if (stored || req.last_element) items_applied++;
    if (!req.last_element) return 1'b0;
    res = search_best_rectangle(rows, cols);
    load_pos = 0;
    return 1'b1;
  endfunction

  function automatic logic [15:0] random_element();
    logic [15:0] v;
    case ($urandom_range(3))
      0: v = 16'($urandom);
      1: v = 16'($urandom_range(16) - 8);
      2: begin
        case ($urandom_range(3))
          0: v = 16'h7fff;
          1: v = 16'h8000;
          2: v = 16'h0000;
          default: v = 16'hffff;
        endcase
      end
      default: v = 16'($urandom_range(2000) - 1000);
    endcase
    return v;
  endfunction

  function automatic logic [8:0] random_count();
    case ($urandom_range(19))
      0: return 9'd0;
      1, 2: return 9'($urandom_range(9, 16));
      default: return 9'($urandom_range(1, 8));
    endcase
  endfunction

  function automatic void plan_cfg(int rows, int cols);
    plan_step_t s;
    s.is_cfg = 1'b1;
    s.rows_val = rows[8:0];
    s.cols_val = cols[8:0];
    s.req = '0;
    s.typed = 1'b0;
    s.want = '0;
    plan.push_back(s);
  endfunction

  function automatic void plan_item(int e, bit last);
    plan_step_t s;
    s.is_cfg = 1'b0;
    s.rows_val = '0;
    s.cols_val = '0;
    s.req.element = e[15:0];
    s.req.last_element = last;
    s.typed = 1'b0;
    s.want = '0;
    plan.push_back(s);
  endfunction

  function automatic void plan_checked(int e, int sum, int t, int l, int b, int r);
    plan_item(e, 1'b1);
    plan[plan.size()-1].typed = 1'b1;
    plan[plan.size()-1].want.best_sum = sum;
    plan[plan.size()-1].want.top_row = t[8:0];
    plan[plan.size()-1].want.left_col = l[8:0];
    plan[plan.size()-1].want.bottom_row = b[8:0];
    plan[plan.size()-1].want.right_col = r[8:0];
  endfunction

  task automatic report_field(string name, longint want, longint got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endtask

  task automatic send_request(input mss_pkg::request_t req, input bit typed,
                              input mss_pkg::result_t want, input int idle_pct);
    int gap;
    bit produces;
    mss_pkg::result_t predicted;
    gap = 0;
    while ($urandom_range(99) < idle_pct && gap < 20) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    request <= req;
    do @(posedge clk); while (busy);
    produces = predict_request(req, predicted);
    if (produces) awaited_rectangles.push_back(typed ? want : predicted);
  endtask

  task automatic wait_quiet();
    start <= 1'b0;
    do @(posedge clk); while (awaited_rectangles.size() != 0 || busy);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_counts(input logic [8:0] rows, input logic [8:0] cols);
    cfg_we <= 1'b1;
    cfg_index <= mss_pkg::REG_ROW_COUNT;
    cfg_data <= rows;
    @(posedge clk);
    rows_reg = rows;
    cfg_index <= mss_pkg::REG_COL_COUNT;
    cfg_data <= cols;
    @(posedge clk);
    cols_reg = cols;
    cfg_we <= 1'b0;
  endtask

  task automatic play_matrix(input int idle_pct, input shape_t shape);
    int unsigned total;
    int unsigned count;
    int unsigned kind;
    mss_pkg::request_t req;
    total = clamp_count(32'(rows_reg), MAX_R) * clamp_count(32'(cols_reg), MAX_C);
    kind = $urandom_range(99);
    count = total;
    if (total > 1 && total <= written_extent && (shape == SHAPE_EARLY || kind >= 88))
      count = $urandom_range(1, (total - 1 < 16) ? total - 1 : 16);
    else if (kind < 10)
      count = total + $urandom_range(1, 3);
    for (int unsigned i = 0; i < count; i++) begin
      req.element = random_element();
      req.last_element = (i == count - 1);
      send_request(req, 1'b0, '0, idle_pct);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (awaited_rectangles.size() == 0) begin
        $display("%0t: result with no request awaiting it, expected none, got sum %0d",
                 $time, result.best_sum);
        errors++;
      end else begin
        oldest = awaited_rectangles.pop_front();
        report_field("best_sum", oldest.best_sum, result.best_sum);
        report_field("top_row", oldest.top_row, result.top_row);
        report_field("left_col", oldest.left_col, result.left_col);
        report_field("bottom_row", oldest.bottom_row, result.bottom_row);
        report_field("right_col", oldest.right_col, result.right_col);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    int unsigned goal;
    int idle_pct [3];
    idle_pct = '{0, 72, 9};

    plan_cfg(0, 0);
    plan_checked(32767, 32767, 1, 1, 1, 1);
    plan_checked(-32768, -32768, 1, 1, 1, 1);
    plan_cfg(2, 2);
    plan_item(0, 1'b0);
    plan_item(0, 1'b0);
    plan_item(0, 1'b0);
    plan_checked(0, 0, 1, 1, 1, 1);
    plan_item(-1, 1'b0);
    plan_item(-2, 1'b0);
    plan_item(-3, 1'b0);
    plan_checked(-4, -1, 1, 1, 1, 1);
    plan_cfg(1, 2);
    plan_item(5, 1'b0);
    plan_item(-7, 1'b0);
    plan_item(100, 1'b1);
    plan_cfg(2, 2);
    plan_item(9, 1'b0);
    plan_item(9, 1'b1);
    plan_cfg(1, 4);
    plan_item(1, 1'b0);
    plan_item(1, 1'b0);
    plan_item(-2, 1'b0);
    plan_checked(2, 2, 1, 1, 1, 2);
    plan_cfg(1, 3);
    plan_item(32767, 1'b0);
    plan_item(-32768, 1'b0);
    plan_checked(32767, 32767, 1, 1, 1, 1);
    plan_cfg(2, 2);
    plan_item(11, 1'b0);
    plan_item(-6, 1'b0);
    plan_item(7, 1'b0);
    plan_cfg(1, 3);
    plan_item(50, 1'b1);

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        wait_quiet();
        write_counts(plan[i].rows_val, plan[i].cols_val);
      end else begin
        send_request(plan[i].req, plan[i].typed, plan[i].want, 0);
      end
    end

    wait_quiet();
    write_counts(9'd511, 9'd1);
    play_matrix(0, SHAPE_RANDOM);
    wait_quiet();
    write_counts(9'd1, 9'd300);
    play_matrix(9, SHAPE_EARLY);
    wait_quiet();
    write_counts(9'd1, 9'd256);
    play_matrix(0, SHAPE_EARLY);

    goal = items_applied;
    foreach (idle_pct[p]) begin
      goal += PHASE_ITEMS;
      while (items_applied < goal) begin
        if ($urandom_range(2) == 0) begin
          wait_quiet();
          write_counts(random_count(), random_count());
        end
        play_matrix(idle_pct[p], SHAPE_RANDOM);
      end
    end

    wait_quiet();
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
